### rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants for the LRU permission cache: request and
// response payloads, operation codes, sequencer states and stored key words.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int ENTRIES_DEF = 64;

    localparam logic [6:0] REMOVED_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_INVAL  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Kind of rank update applied during a metadata pass
    typedef enum logic [1:0] {
        PASS_TOUCH,
        PASS_INSERT,
        PASS_DROP
    } pass_t;

    typedef struct packed {
        op_t         operation;
        logic [63:0] user_id;
        logic [63:0] channel_id;
        logic [63:0] perm_value;
        logic [63:0] required_mask;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] found_value;
        logic        granted;
        logic        evicted;
        logic [6:0]  removed_count;
    } rsp_t;

    typedef struct packed {
        logic [63:0] user_id;
        logic [63:0] channel_id;
        logic [63:0] mask;
    } key_t;

endpackage

### rtl/lru_permission_cache.sv
// ----------------------------------------------------------------------------
// lru_permission_cache
// Fully associative cache of 64-bit permission masks keyed by user and
// channel, with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request at a time. Every operation is a scan over the ENTRIES slots of
// the key and metadata memories, one slot per cycle through their single
// read port. A lookup miss is a single search pass; a lookup hit, an insert
// hit or an insert of a new key adds a rank-update pass. A channel
// invalidate closes the rank gap of each entry that it removes with its own
// pass. Operation code 3 returns an all-zero response. After reset the block
// clears its metadata memory before it takes the first request. The response
// sits in an output register, so a new request is taken while the previous
// response waits.
module lru_permission_cache #(
    parameter int ENTRIES = lpc_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lpc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lpc_pkg::rsp_t rsp
);

    import lpc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam logic [IW:0]   DEPTH_C = (IW + 1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_C  = IW'(ENTRIES - 1);
    localparam logic [OW-1:0] FULL_C  = OW'(ENTRIES);

    state_t        state_reg, state_next;
    pass_t         pass_reg, pass_next;
    req_t          req_reg, req_next;
    logic [IW:0]   scan_cnt_reg, scan_cnt_next;
    logic          proc_vld_reg, proc_vld_next;
    logic [IW-1:0] proc_idx_reg, proc_idx_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] hit_age_reg, hit_age_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic          hit_reg, hit_next;
    logic [63:0]   found_reg, found_next;
    logic          granted_reg, granted_next;
    logic          evicted_reg, evicted_next;
    logic [6:0]    removed_reg, removed_next;
    rsp_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          key_we;
    logic [IW-1:0] key_waddr;
    key_t          key_wdata;
    key_t          key_rd;
    logic          meta_we;
    logic [IW-1:0] meta_waddr;
    logic [IW:0]   meta_wdata;
    logic [IW:0]   meta_rd;
    logic [IW-1:0] rd_addr;

    logic          ent_vld;
    logic [IW-1:0] ent_age;
    logic          full;
    logic          key_match;
    logic          chan_match;
    logic [IW-1:0] victim;

    lpc_ram #(
        .WIDTH ($bits(key_t)),
        .DEPTH (ENTRIES),
        .ADDR_W(IW)
    ) u_key_ram (
        .clk  (clk),
        .we   (key_we),
        .waddr(key_waddr),
        .wdata(key_wdata),
        .raddr(rd_addr),
        .rdata(key_rd)
    );

    // Metadata word: valid bit on top, recency rank below
    lpc_ram #(
        .WIDTH (IW + 1),
        .DEPTH (ENTRIES),
        .ADDR_W(IW)
    ) u_meta_ram (
        .clk  (clk),
        .we   (meta_we),
        .waddr(meta_waddr),
        .wdata(meta_wdata),
        .raddr(rd_addr),
        .rdata(meta_rd)
    );

    assign ent_vld    = meta_rd[IW];
    assign ent_age    = meta_rd[IW-1:0];
    assign full       = (occ_reg == FULL_C);
    assign key_match  = ent_vld && (key_rd.user_id == req_reg.user_id)
                        && (key_rd.channel_id == req_reg.channel_id);
    assign chan_match = ent_vld && (key_rd.channel_id == req_reg.channel_id);
    assign rd_addr    = scan_cnt_reg[IW-1:0];

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_cnt_reg   <= '0;
            proc_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            occ_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            proc_vld_reg   <= proc_vld_next;
            free_found_reg <= free_found_next;
            occ_reg        <= occ_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg     <= pass_next;
        req_reg      <= req_next;
        proc_idx_reg <= proc_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_age_reg  <= hit_age_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        granted_reg  <= granted_next;
        evicted_reg  <= evicted_next;
        removed_reg  <= removed_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        req_next        = req_reg;
        scan_cnt_next   = scan_cnt_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_age_next    = hit_age_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        old_idx_next    = old_idx_reg;
        occ_next        = occ_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        granted_next    = granted_reg;
        evicted_next    = evicted_reg;
        removed_next    = removed_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        victim          = free_idx_reg;

        key_we     = 1'b0;
        key_waddr  = proc_idx_reg;
        key_wdata  = '{user_id:    req_reg.user_id,
                       channel_id: req_reg.channel_id,
                       mask:       req_reg.perm_value};
        meta_we    = 1'b0;
        meta_waddr = proc_idx_reg;
        meta_wdata = meta_rd;

        // Issue the next slot read while scanning
        if ((state_reg == ST_SEARCH || state_reg == ST_UPDATE) && scan_cnt_reg != DEPTH_C)
        begin
            proc_vld_next = 1'b1;
            proc_idx_next = rd_addr;
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                meta_we       = 1'b1;
                meta_waddr    = rd_addr;
                meta_wdata    = '0;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (rd_addr == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req;
                    hit_next        = 1'b0;
                    found_next      = '0;
                    granted_next    = 1'b0;
                    evicted_next    = 1'b0;
                    removed_next    = '0;
                    free_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    case (req.operation)
                        OP_LOOKUP, OP_INSERT, OP_INVAL: state_next = ST_SEARCH;
                        default:                        state_next = ST_RESULT;
                    endcase
                end
            end

            ST_SEARCH:
            begin
                if (proc_vld_reg)
                begin
                    case (req_reg.operation)
                        OP_LOOKUP, OP_INSERT:
                        begin
                            if (!ent_vld && !free_found_reg)
                            begin
                                free_idx_next   = proc_idx_reg;
                                free_found_next = 1'b1;
                            end
                            if (ent_vld && ent_age == IW'(occ_reg - OW'(1)))
                            begin
                                old_idx_next = proc_idx_reg;
                            end

                            if (key_match)
                            begin
                                hit_next      = 1'b1;
                                hit_idx_next  = proc_idx_reg;
                                hit_age_next  = ent_age;
                                pass_next     = PASS_TOUCH;
                                state_next    = ST_UPDATE;
                                scan_cnt_next = '0;
                                proc_vld_next = 1'b0;
                                if (req_reg.operation == OP_LOOKUP)
                                begin
                                    found_next   = key_rd.mask;
                                    granted_next = ((key_rd.mask & req_reg.required_mask)
                                                    == req_reg.required_mask);
                                end
                                else
                                begin
                                    key_we = 1'b1;
                                end
                            end
                            else if (proc_idx_reg == LAST_C)
                            begin
                                if (req_reg.operation == OP_LOOKUP)
                                begin
                                    state_next = ST_RESULT;
                                end
                                else
                                begin
                                    // Evict the oldest slot when full, else fill a free one
                                    victim        = full ? old_idx_next : free_idx_next;
                                    evicted_next  = full;
                                    key_we        = 1'b1;
                                    key_waddr     = victim;
                                    hit_idx_next  = victim;
                                    pass_next     = PASS_INSERT;
                                    state_next    = ST_UPDATE;
                                    scan_cnt_next = '0;
                                    proc_vld_next = 1'b0;
                                    if (!full)
                                    begin
                                        occ_next = occ_reg + 1'b1;
                                    end
                                end
                            end
                        end

                        OP_INVAL:
                        begin
                            if (chan_match)
                            begin
                                hit_idx_next  = proc_idx_reg;
                                hit_age_next  = ent_age;
                                occ_next      = occ_reg - 1'b1;
                                if (removed_reg != REMOVED_MAX)
                                begin
                                    removed_next = removed_reg + 1'b1;
                                end
                                pass_next     = PASS_DROP;
                                state_next    = ST_UPDATE;
                                scan_cnt_next = '0;
                                proc_vld_next = 1'b0;
                            end
                            else if (proc_idx_reg == LAST_C)
                            begin
                                state_next = ST_RESULT;
                            end
                        end

                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_UPDATE:
            begin
                if (proc_vld_reg)
                begin
                    meta_we = 1'b1;
                    case (pass_reg)
                        PASS_TOUCH:
                        begin
                            if (proc_idx_reg == hit_idx_reg)
                            begin
                                meta_wdata = {1'b1, {IW{1'b0}}};
                            end
                            else if (ent_vld && ent_age < hit_age_reg)
                            begin
                                meta_wdata = {1'b1, ent_age + 1'b1};
                            end
                        end

                        PASS_INSERT:
                        begin
                            if (proc_idx_reg == hit_idx_reg)
                            begin
                                meta_wdata = {1'b1, {IW{1'b0}}};
                            end
                            else if (ent_vld)
                            begin
                                meta_wdata = {1'b1, ent_age + 1'b1};
                            end
                        end

                        PASS_DROP:
                        begin
                            if (proc_idx_reg == hit_idx_reg)
                            begin
                                meta_wdata = {1'b0, {IW{1'b0}}};
                            end
                            else if (ent_vld && ent_age > hit_age_reg)
                            begin
                                meta_wdata = {1'b1, ent_age - 1'b1};
                            end
                        end

                        default:
                        begin
                            meta_we = 1'b0;
                        end
                    endcase

                    if (proc_idx_reg == LAST_C)
                    begin
                        // Resume the channel search after the dropped slot
                        if (pass_reg == PASS_DROP && hit_idx_reg != LAST_C)
                        begin
                            state_next    = ST_SEARCH;
                            scan_cnt_next = {1'b0, hit_idx_reg} + 1'b1;
                            proc_vld_next = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next = '{hit:           hit_reg,
                                 found_value:   found_reg,
                                 granted:       granted_reg,
                                 evicted:       evicted_reg,
                                 removed_count: removed_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_C)
        else $error("occupancy above cache depth");

    a_evict_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted |-> !rsp.hit && !rsp.granted
                                     && rsp.removed_count == '0 && rsp.found_value == '0)
        else $error("eviction reported with fields of another operation");

    a_grant_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.granted |-> rsp.hit)
        else $error("grant reported without a hit");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_RESULT))
        else $error("response raised outside the result state");
`endif

endmodule

### rtl/lpc_ram.sv
// ----------------------------------------------------------------------------
// lpc_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lpc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sim/lpc_cache_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpc_cache_checker
// Watches both channels of the LRU permission cache and keeps its own copy of
// the cache contents and recency ranks. Every accepted request is run through
// that copy, and each response is compared field by field, in order, with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lpc_cache_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  lpc_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  lpc_pkg::rsp_t rsp,
    output int            mismatches,
    output int            pending,
    output int            evict_count,
    output int            grant_count,
    output int            max_removed
);

    import lpc_pkg::*;

    localparam int SLOTS = ENTRIES_DEF;
    localparam int REPORT_LIMIT = 10;

    logic        slot_used [SLOTS];
    logic [63:0] slot_user [SLOTS];
    logic [63:0] slot_chan [SLOTS];
    logic [63:0] slot_mask [SLOTS];
    int          slot_rank [SLOTS];
    int          used_count;

    rsp_t        awaited_rsp [$];

    function automatic int find_slot(input logic [63:0] user, input logic [63:0] chan);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_user[i] == user && slot_chan[i] == chan)
                return i;
        end
        return -1;
    endfunction

    // Move one slot to the front; everything newer shifts back by one.
    function automatic void promote(input int idx);
        int a;
        a = slot_rank[idx];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_rank[i] < a)
                slot_rank[i]++;
        end
        slot_rank[idx] = 0;
    endfunction

    // Free one slot and close the gap it leaves in the ranks.
    function automatic void retire(input int idx);
        int a;
        a = slot_rank[idx];
        slot_used[idx] = 1'b0;
        slot_rank[idx] = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_rank[i] > a)
                slot_rank[i]--;
        end
        if (used_count > 0)
            used_count--;
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int   idx;
        int   oldest;
        int   removed;
        o = '0;
        case (r.operation)
            OP_LOOKUP:
            begin
                idx = find_slot(r.user_id, r.channel_id);
                if (idx >= 0)
                begin
                    o.hit         = 1'b1;
                    o.found_value = slot_mask[idx];
                    o.granted     = ((slot_mask[idx] & r.required_mask) == r.required_mask);
                    promote(idx);
                end
            end
            OP_INSERT:
            begin
                idx = find_slot(r.user_id, r.channel_id);
                if (idx >= 0)
                begin
                    o.hit = 1'b1;
                    slot_mask[idx] = r.perm_value;
                    promote(idx);
                end
                else
                begin
                    if (used_count >= SLOTS)
                    begin
                        oldest = -1;
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slot_used[i] &&
                                (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
                                oldest = i;
                        end
                        if (oldest >= 0)
                        begin
                            retire(oldest);
                            o.evicted = 1'b1;
                        end
                    end
                    idx = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_used[i] && idx < 0)
                            idx = i;
                    end
                    if (idx >= 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (slot_used[i])
                                slot_rank[i]++;
                        end
                        slot_used[idx] = 1'b1;
                        slot_user[idx] = r.user_id;
                        slot_chan[idx] = r.channel_id;
                        slot_mask[idx] = r.perm_value;
                        slot_rank[idx] = 0;
                        used_count++;
                    end
                end
            end
            OP_INVAL:
            begin
                removed = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i] && slot_chan[i] == r.channel_id)
                    begin
                        retire(i);
                        if (removed < int'(REMOVED_MAX))
                            removed++;
                    end
                end
                o.removed_count = removed[6:0];
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        rsp_t made;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_user[i] = '0;
                slot_chan[i] = '0;
                slot_mask[i] = '0;
                slot_rank[i] = 0;
            end
            used_count  = 0;
            awaited_rsp.delete();
            mismatches  = 0;
            pending     = 0;
            evict_count = 0;
            grant_count = 0;
            max_removed = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: response with no request outstanding: hit=%0b value=%h",
                                 $realtime, rsp.hit, rsp.found_value);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.hit !== want.hit || rsp.found_value !== want.found_value ||
                        rsp.granted !== want.granted || rsp.evicted !== want.evicted ||
                        rsp.removed_count !== want.removed_count)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: response mismatch", $realtime);
                            $display({"  expected hit=%0b value=%h granted=%0b",
                                      " evicted=%0b removed=%0d"},
                                     want.hit, want.found_value, want.granted, want.evicted,
                                     want.removed_count);
                            $display({"  actual   hit=%0b value=%h granted=%0b",
                                      " evicted=%0b removed=%0d"},
                                     rsp.hit, rsp.found_value, rsp.granted, rsp.evicted,
                                     rsp.removed_count);
                        end
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                made = apply_request(req);
                awaited_rsp.push_back(made);
                if (made.evicted)
                    evict_count++;
                if (made.granted)
                    grant_count++;
                if (int'(made.removed_count) > max_removed)
                    max_removed = int'(made.removed_count);
            end
            pending = awaited_rsp.size();
        end
    end

endmodule

### sim/lru_permission_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_permission_cache_tb
// Drives the LRU permission cache with a short directed list of lookups,
// inserts, updates and channel invalidates, then with random segments that
// fill the cache, force evictions and clear whole channels, while both sides
// idle at random. A side checker predicts and compares every response.
// ----------------------------------------------------------------------------
module lru_permission_cache_tb;

    import lpc_pkg::*;

    localparam int          SEGMENTS       = 10;
    localparam int          SEGMENT_LEN    = 150;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          END_PAUSE      = 4 * ENTRIES_DEF;
    localparam int          HOLD_AT        = 4000;
    localparam int          HOLD_CYCLES    = 800;
    localparam logic [63:0] ONES           = '1;
    localparam logic [63:0] ZERO           = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int mismatches;
    int pending;
    int evict_count;
    int grant_count;
    int max_removed;

    int n_lookup;
    int n_insert;
    int n_inval;
    int n_none;

    logic [63:0] user_pool [80];
    logic [63:0] chan_pool [8];
    logic [63:0] mask_pool [4];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    lru_permission_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lpc_cache_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .pending     (pending),
        .evict_count (evict_count),
        .grant_count (grant_count),
        .max_removed (max_removed)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t make_request(input op_t op, input logic [63:0] user,
                                          input logic [63:0] chan, input logic [63:0] value,
                                          input logic [63:0] need);
        req_t r;
        r.operation     = op;
        r.user_id       = user;
        r.channel_id    = chan;
        r.perm_value    = value;
        r.required_mask = need;
        return r;
    endfunction

    // kind 0: churn over a small key set, no invalidates
    // kind 1: same keys with channel invalidates mixed in
    // kind 2: many users on one channel, cleared at the end of the segment
    function automatic req_t random_request(input int kind);
        req_t        r;
        int          roll;
        logic [63:0] base;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            r.operation = OP_NONE;
        else if (kind == 1 && roll < 13)
            r.operation = OP_INVAL;
        else if (roll < ((kind == 2) ? 65 : 55))
            r.operation = OP_INSERT;
        else
            r.operation = OP_LOOKUP;

        if (kind == 2)
            r.user_id = user_pool[$urandom_range(0, 79)];
        else if ($urandom_range(0, 99) < 88)
            r.user_id = user_pool[$urandom_range(0, 11)];
        else
            r.user_id = rand64();

        if (kind == 2 && $urandom_range(0, 99) < 92)
            r.channel_id = chan_pool[0];
        else if ($urandom_range(0, 99) < 90)
            r.channel_id = chan_pool[$urandom_range(0, 7)];
        else
            r.channel_id = rand64();

        roll = $urandom_range(0, 99);
        if (roll < 10)
            r.perm_value = ZERO;
        else if (roll < 20)
            r.perm_value = ONES;
        else if (roll < 70)
            r.perm_value = mask_pool[$urandom_range(0, 3)];
        else
            r.perm_value = rand64();

        base = mask_pool[$urandom_range(0, 3)];
        roll = $urandom_range(0, 99);
        if (roll < 20)
            r.required_mask = ZERO;
        else if (roll < 30)
            r.required_mask = ONES;
        else if (roll < 60)
            r.required_mask = base;
        else if (roll < 85)
            r.required_mask = base & rand64();
        else
            r.required_mask = rand64();
        return r;
    endfunction

    // Hold the request until it is taken; valid never looks at stall.
    task automatic send_request(input req_t r);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        case (r.operation)
            OP_LOOKUP: n_lookup++;
            OP_INSERT: n_insert++;
            OP_INVAL:  n_inval++;
            default:   n_none++;
        endcase
    endtask

    initial
    begin : stimulus
        int kind;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        n_lookup  = 0;
        n_insert  = 0;
        n_inval   = 0;
        n_none    = 0;
        for (int i = 0; i < 80; i++)
            user_pool[i] = rand64();
        for (int i = 0; i < 8; i++)
            chan_pool[i] = rand64();
        for (int i = 0; i < 4; i++)
            mask_pool[i] = rand64();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // lookup on an empty cache, then the unused operation code
        send_request(make_request(OP_LOOKUP, ZERO, ZERO, ZERO, ZERO));
        send_request(make_request(OP_NONE, ONES, ONES, ONES, ONES));
        send_request(make_request(OP_INSERT, ZERO, ZERO, ONES, ONES));
        send_request(make_request(OP_INSERT, ONES, ONES, ZERO, ZERO));
        // zero required mask grants on any hit
        send_request(make_request(OP_LOOKUP, ZERO, ZERO, ONES, ZERO));
        send_request(make_request(OP_LOOKUP, ZERO, ZERO, ZERO, ONES));
        send_request(make_request(OP_LOOKUP, ONES, ONES, ONES, ONES));
        send_request(make_request(OP_LOOKUP, ONES, ONES, ZERO, ZERO));
        // half of a key matching is still a miss
        send_request(make_request(OP_LOOKUP, ZERO, ONES, ZERO, ZERO));
        send_request(make_request(OP_INSERT, ZERO, ZERO, 64'h5555_5555_5555_5555, ZERO));
        send_request(make_request(OP_LOOKUP, ZERO, ZERO, ZERO, 64'hAAAA_AAAA_AAAA_AAAA));
        send_request(make_request(OP_LOOKUP, ZERO, ZERO, ZERO, 64'h5555_5555_5555_5555));
        send_request(make_request(OP_INVAL, ZERO, 64'h1234, ZERO, ZERO));
        send_request(make_request(OP_INSERT, ONES, ZERO, 64'hAAAA_AAAA_AAAA_AAAA, ONES));
        send_request(make_request(OP_INVAL, ONES, ZERO, ONES, ONES));
        send_request(make_request(OP_LOOKUP, ZERO, ZERO, ZERO, ZERO));
        send_request(make_request(OP_INVAL, ZERO, ONES, ZERO, ZERO));
        send_request(make_request(OP_LOOKUP, ONES, ONES, ZERO, ZERO));
        send_request(make_request(OP_NONE, ZERO, ZERO, ZERO, ZERO));

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            kind = seg % 3;
            for (int k = 0; k < SEGMENT_LEN; k++)
            begin
                if (kind == 2 && k == SEGMENT_LEN - 1)
                    send_request(make_request(OP_INVAL, rand64(), chan_pool[0],
                                              rand64(), rand64()));
                else
                    send_request(random_request(kind));
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (END_PAUSE) @(posedge clk);

        $display("Sent %0d requests: %0d lookups, %0d inserts, %0d invalidates, %0d no-ops.",
                 n_lookup + n_insert + n_inval + n_none, n_lookup, n_insert, n_inval, n_none);
        $display({"Saw %0d grants, %0d evictions, up to %0d entries cleared at once;",
                  " %0d mismatches."},
                 grant_count, evict_count, max_removed, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("lru_permission_cache_tb: done, clean");
        else
            $display("lru_permission_cache_tb: done, errors");
        $finish;
    end

    initial
    begin : receiver
        int run;
        int gap;
        int ticks;
        bit held;
        rsp_stall = 1'b0;
        ticks     = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = idle_len();
            // one long hold-off so the block backs up into its request side
            if (!held && ticks >= HOLD_AT)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                run = $urandom_range(50, 200);
            else
                run = $urandom_range(1, 6);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            repeat (run) @(posedge clk);
            ticks += gap + run;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timed out after %0d cycles with no request or response moving.", quiet);
        $display("lru_permission_cache_tb: done, errors");
        $finish;
    end

endmodule
